// ===== rtl/lpht_pkg.sv =====
// ============================================================================
// lpht_pkg: shared types and constants for the linear-probe hash table
// Holds sizes, operation codes, slot marks and the FNV constants.
// ============================================================================
package lpht_pkg;

    localparam int CAPACITY   = 64;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = IDX_W + 1;
    localparam int KEY_BYTES  = 8;
    localparam int KEY_W      = 64;
    localparam int VAL_W      = 64;
    localparam int LIMIT_W    = 7;
    localparam int BYTE_CNT_W = 4;

    localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 7'd48;
    localparam logic [31:0]        FNV_BASIS      = 32'd2166136261;
    localparam logic [31:0]        FNV_PRIME      = 32'd16777619;

    localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES);

    typedef enum logic [1:0] {
        OP_SET = 2'd0,
        OP_GET = 2'd1,
        OP_DEL = 2'd2,
        OP_NOP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_TOMB  = 2'd1,
        MARK_LIVE  = 2'd2,
        MARK_RSVD  = 2'd3
    } t_mark;

    typedef struct packed {
        logic ok;
        logic new_key;
        logic full_res;
    } t_flags;

endpackage

// ===== rtl/lpht_hash.sv =====
// ============================================================================
// lpht_hash: iterative FNV-1a hash over the key bytes
// One byte is folded in and multiplied by the prime each cycle.
// ============================================================================
module lpht_hash
    import lpht_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [KEY_W-1:0]      i_key,
    output logic                  o_done,
    output logic [IDX_W-1:0]      o_home
);

    logic                  r_busy, n_busy;
    logic [BYTE_CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]           r_h, n_h;
    logic [KEY_W-1:0]      r_key, n_key;
    logic                  r_done, n_done;
    logic [31:0]           w_x;

    assign w_x = r_h ^ {24'd0, r_key[7:0]};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_h    = r_h;
        n_key  = r_key;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_h    = FNV_BASIS;
            n_key  = i_key;
        end else if (r_busy) begin
            n_h   = w_x * FNV_PRIME;
            n_key = r_key >> 8;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == BYTE_CNT_W'(KEY_BYTES - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_h   <= n_h;
        r_key <= n_key;
    end

    assign o_done = r_done;
    assign o_home = r_h[IDX_W-1:0];

endmodule

// ===== rtl/linear_probe_hash_table_unit.sv =====
// ============================================================================
// linear_probe_hash_table_unit: open-addressing key-value store
// Set, get and delete of 64-bit keys with FNV-1a hashing and linear probing.
// ============================================================================
//
//  Channel   Direction  Handshake               Payload
//  request   in         i_valid / o_stall       i_operation, i_key, i_value
//  result    out        o_valid / i_stall       o_ok, o_new_key, o_full_res,
//                                               o_value_out
//  config    in         i_cfg_we                i_cfg_data (load limit)
//
// Hashing is a start step and eight steps of the shared FNV multiply loop,
// one key byte each. Each probed slot then goes through a read state and a
// check state, up to CAPACITY slots. A finish state, a result state and the
// idle state that takes the next request close the sequence.
// The single read port of the slot memories sets the probe rate.
// Reset is synchronous and active low. It clears the marks, which live in
// flip-flops, at once, so no clearing pass is needed.
// The block takes one request at a time; o_stall stays high from acceptance
// until its result has been taken, and a stalled result holds its payload.
//
module linear_probe_hash_table_unit
    import lpht_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic [KEY_W-1:0]   i_key,
    input  logic [VAL_W-1:0]   i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_ok,
    output logic               o_new_key,
    output logic               o_full_res,
    output logic [VAL_W-1:0]   o_value_out,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_HASH  = 6'b000010,
        S_READ  = 6'b000100,
        S_CHECK = 6'b001000,
        S_FIN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Slot stores. Marks live in flip-flops so reset empties them at once;
    // keys and values are memories with a registered read port.
    t_mark            r_mark [CAPACITY];
    logic [KEY_W-1:0] r_skey [CAPACITY];
    logic [VAL_W-1:0] r_sval [CAPACITY];

    logic [LIMIT_W-1:0] r_limit;
    logic [CNT_W-1:0]   r_used;
    t_op                r_op;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_val;
    logic [IDX_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_n;
    logic               r_tomb_ok;
    logic [IDX_W-1:0]   r_tomb;
    logic [KEY_W-1:0]   r_rd_key;
    logic [VAL_W-1:0]   r_rd_val;
    t_mark              r_rd_mark;
    logic               r_hit;
    logic               r_slot_ok;
    logic               r_slot_empty;
    logic [IDX_W-1:0]   r_slot;
    t_flags             r_flags;

    logic             w_hash_start, w_hash_done;
    logic [IDX_W-1:0] w_home;
    logic             w_accept;
    logic             w_set_refused;
    logic [VAL_W-1:0] w_vout;

    assign w_accept     = (r_state == S_IDLE) && i_valid;
    assign w_hash_start = w_accept;

    // A set is refused at the load limit or when no slot is free.
    assign w_set_refused = ({1'b0, r_used} >= {1'b0, r_limit}) || !r_slot_ok;

    lpht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_key   (i_key & KEY_MASK),
        .o_done  (w_hash_done),
        .o_home  (w_home)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_HASH;
            S_HASH:  if (w_hash_done) n_state = S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                // Probe ends at an empty slot, a matching live slot, or after
                // every slot has been seen.
                if (r_rd_mark == MARK_EMPTY ||
                    (r_rd_mark == MARK_LIVE && r_rd_key == r_key) ||
                    r_n == CNT_W'(CAPACITY - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_READ;
                end
            end
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= LOAD_LIMIT_RST;
            r_used  <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_mark[i] <= MARK_EMPTY;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (r_state == S_FIN && r_op == OP_SET && r_slot_ok &&
                {1'b0, r_used} < {1'b0, r_limit}) begin
                if (!r_hit && r_slot_empty) begin
                    r_used <= r_used + 1'b1;
                end
                r_mark[r_slot] <= MARK_LIVE;
            end
            if (r_state == S_FIN && r_op == OP_DEL && r_hit) begin
                r_mark[r_slot] <= MARK_TOMB;
            end
        end
    end

    // Memory ports: reads in S_READ at the probe index, one write at finish.
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_key  <= r_skey[r_idx];
            r_rd_mark <= r_mark[r_idx];
        end
        if (r_state == S_FIN && r_op == OP_SET && r_slot_ok &&
            {1'b0, r_used} < {1'b0, r_limit}) begin
            r_skey[r_slot] <= r_key;
            r_sval[r_slot] <= r_val;
        end
        r_rd_val <= r_sval[r_slot];
    end

    // Datapath control for the probe walk.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op         <= t_op'(i_operation);
            r_key        <= i_key & KEY_MASK;
            r_val        <= i_value;
            r_n          <= '0;
            r_tomb_ok    <= 1'b0;
            r_hit        <= 1'b0;
            r_slot_ok    <= 1'b0;
            r_slot_empty <= 1'b0;
        end
        if (r_state == S_HASH && w_hash_done) begin
            r_idx <= w_home;
        end
        if (r_state == S_CHECK) begin
            if (r_rd_mark == MARK_EMPTY) begin
                r_slot_ok    <= 1'b1;
                r_slot_empty <= !r_tomb_ok;
                r_slot       <= r_tomb_ok ? r_tomb : r_idx;
            end else if (r_rd_mark == MARK_LIVE && r_rd_key == r_key) begin
                r_hit        <= 1'b1;
                r_slot_ok    <= 1'b1;
                r_slot_empty <= 1'b0;
                r_slot       <= r_idx;
            end else begin
                if (r_rd_mark == MARK_TOMB && !r_tomb_ok) begin
                    r_tomb_ok <= 1'b1;
                    r_tomb    <= r_idx;
                end
                if (r_n == CNT_W'(CAPACITY - 1)) begin
                    r_slot_ok    <= r_tomb_ok || (r_rd_mark == MARK_TOMB);
                    r_slot_empty <= 1'b0;
                    r_slot       <= r_tomb_ok ? r_tomb : r_idx;
                end
            end
            r_idx <= r_idx + 1'b1;
            r_n   <= r_n + 1'b1;
        end
        if (r_state == S_FIN) begin
            case (r_op)
                OP_SET: begin
                    if (w_set_refused) begin
                        r_flags <= '{ok: 1'b0, new_key: 1'b0, full_res: 1'b1};
                    end else begin
                        r_flags <= '{ok: 1'b1, new_key: !r_hit, full_res: 1'b0};
                    end
                end
                OP_GET:  r_flags <= '{ok: r_hit, new_key: 1'b0, full_res: 1'b0};
                OP_DEL:  r_flags <= '{ok: r_hit, new_key: 1'b0, full_res: 1'b0};
                default: r_flags <= '0;
            endcase
        end
    end

    // The value of the hit slot is read during S_FIN (slot fixed by then).
    assign w_vout = (r_op == OP_GET && r_hit) ? r_rd_val : '0;

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_ok        = r_flags.ok;
    assign o_new_key   = r_flags.new_key;
    assign o_full_res  = r_flags.full_res;
    assign o_value_out = w_vout;

endmodule

// ===== rtl/lpht_checker.sv =====
// ============================================================================
// lpht_checker: port-level checks for the hash table unit
// Watches the handshakes and result flags over time.
// ============================================================================
module lpht_checker
    import lpht_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic             o_ok,
    input logic             o_new_key,
    input logic             o_full_res,
    input logic [VAL_W-1:0] o_value_out
);

    // An accepted request raises o_stall, so the next one is blocked.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted while a request was in flight");

    // A result is never offered while the block is taking requests.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result shown while idle");

    // A refused set never reports success or a new key.
    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_full_res) |-> (!o_ok && !o_new_key))
        else $error("full result with success flags");

    // A new key implies the set stored, and a value implies a hit.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((!o_new_key || o_ok) && (o_value_out == '0 || o_ok)))
        else $error("inconsistent result flags");

    // A stalled result stays valid and holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_value_out)))
        else $error("stalled result changed");

endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_ok        (o_ok),
    .o_new_key   (o_new_key),
    .o_full_res  (o_full_res),
    .o_value_out (o_value_out)
);
